/* hw/rtl/vsrc_pkg.sv */
// Package for the version string range checker.
// Holds character codes, order codes, register indexes, the parser-to-judge
// struct and the compare functions. No dependencies.
package vsrc_pkg;

    // Character codes
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Largest legal channel value
    localparam logic [31:0] CHAN_MAX = 32'd9;

    // Comparison result codes
    localparam logic [1:0] ORD_LOWER  = 2'd0;
    localparam logic [1:0] ORD_EQUAL  = 2'd1;
    localparam logic [1:0] ORD_HIGHER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_MAJOR   = 2'd0;
    localparam logic [1:0] CFG_MIN_LINE    = 2'd1;
    localparam logic [1:0] CFG_MIN_CHANNEL = 2'd2;
    localparam logic [1:0] CFG_MAJOR_LIMIT = 2'd3;

    // Which dotted part is being parsed
    typedef enum logic [2:0] {
        PART_MAJOR   = 3'b001,
        PART_LINE    = 3'b010,
        PART_CHANNEL = 3'b100
    } t_part;

    // Parsed version handed from the parser to the judge at the end mark
    typedef struct packed {
        logic        ok;
        logic [31:0] major;
        logic [31:0] line;
        logic [3:0]  channel;
    } t_parse_res;

    // Unsigned three-way compare
    function automatic logic [1:0] cmp_u32(input logic [31:0] a, input logic [31:0] b);
        if (a < b) begin
            return ORD_LOWER;
        end else if (a == b) begin
            return ORD_EQUAL;
        end
        return ORD_HIGHER;
    endfunction

    // Channel compare: 0 (release) ranks above every nonzero channel
    function automatic logic [1:0] cmp_channel(input logic [3:0] a, input logic [3:0] b);
        if (a == b) begin
            return ORD_EQUAL;
        end else if (a == 4'd0) begin
            return ORD_HIGHER;
        end else if (b == 4'd0) begin
            return ORD_LOWER;
        end else if (a < b) begin
            return ORD_LOWER;
        end
        return ORD_HIGHER;
    endfunction

endpackage

/* hw/rtl/vsrc_parse.sv */
// Input register and character parser of the version string range checker.
// Accumulates major, line and channel; depends on vsrc_pkg.
module vsrc_parse
    import vsrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_parse_res o_res
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    // Parser state
    t_part       r_part,       n_part;
    logic [31:0] r_acc,        n_acc;
    logic [31:0] r_held_major, n_held_major;
    logic [31:0] r_held_line,  n_held_line;
    logic        r_digit_seen, n_digit_seen;
    logic        r_first_zero, n_first_zero;
    logic        r_err,        n_err;

    logic        advance;
    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] acc_next;
    logic        overflow;

    // A character always moves on; an end mark waits for the judge
    assign advance     = r_in_valid && (!r_in_end || i_res_ready);
    assign o_ready     = !r_in_valid || advance;
    assign accept      = i_valid && o_ready;
    assign o_res_valid = r_in_valid && r_in_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char;
            r_in_end  <= i_end;
        end
    end

    // Digit decode and times-ten accumulate, 36 bits to see overflow
    assign is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign digit    = 4'(r_in_char - CH_ZERO);
    assign acc_next = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {32'd0, digit};
    assign overflow = (acc_next[35:32] != 4'd0);

    // Parser next state
    always_comb begin
        n_part       = r_part;
        n_acc        = r_acc;
        n_held_major = r_held_major;
        n_held_line  = r_held_line;
        n_digit_seen = r_digit_seen;
        n_first_zero = r_first_zero;
        n_err        = r_err;
        if (advance) begin
            if (r_in_end) begin
                n_part       = PART_MAJOR;
                n_acc        = 32'd0;
                n_held_major = 32'd0;
                n_held_line  = 32'd0;
                n_digit_seen = 1'b0;
                n_first_zero = 1'b0;
                n_err        = 1'b0;
            end else if (!r_err) begin
                if (is_digit) begin
                    if ((r_digit_seen && r_first_zero) || overflow) begin
                        n_err = 1'b1;
                    end else begin
                        if (!r_digit_seen) begin
                            n_first_zero = (digit == 4'd0);
                        end
                        n_acc        = acc_next[31:0];
                        n_digit_seen = 1'b1;
                    end
                end else if (r_in_char == CH_DOT) begin
                    if (!r_digit_seen || r_part == PART_CHANNEL) begin
                        n_err = 1'b1;
                    end else begin
                        case (r_part)
                            PART_MAJOR: begin
                                n_held_major = r_acc;
                                n_part       = PART_LINE;
                            end
                            PART_LINE: begin
                                n_held_line = r_acc;
                                n_part      = PART_CHANNEL;
                            end
                            default: begin
                                n_err = 1'b1;
                            end
                        endcase
                        n_acc        = 32'd0;
                        n_digit_seen = 1'b0;
                        n_first_zero = 1'b0;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part       <= PART_MAJOR;
            r_acc        <= 32'd0;
            r_held_major <= 32'd0;
            r_held_line  <= 32'd0;
            r_digit_seen <= 1'b0;
            r_first_zero <= 1'b0;
            r_err        <= 1'b0;
        end else begin
            r_part       <= n_part;
            r_acc        <= n_acc;
            r_held_major <= n_held_major;
            r_held_line  <= n_held_line;
            r_digit_seen <= n_digit_seen;
            r_first_zero <= n_first_zero;
            r_err        <= n_err;
        end
    end

    // Parsed version as seen at the end mark
    always_comb begin
        o_res.ok      = !r_err && (r_part == PART_CHANNEL) && r_digit_seen
                        && (r_acc <= CHAN_MAX);
        o_res.major   = r_held_major;
        o_res.line    = r_held_line;
        o_res.channel = r_acc[3:0];
    end

endmodule

/* hw/rtl/vsrc_judge.sv */
// Configuration registers, range compare and result register of the
// version string range checker. Depends on vsrc_pkg.
module vsrc_judge
    import vsrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_res_valid,
    output logic        o_res_ready,
    input  t_parse_res  i_res,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [71:0] o_data
);

    logic [31:0] r_min_major;
    logic [31:0] r_min_line;
    logic [3:0]  r_min_channel;
    logic [31:0] r_major_limit;

    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic [1:0]  ord_major;
    logic [1:0]  ord_line;
    logic [1:0]  ord_chan;
    logic [1:0]  ord;
    logic        in_range;
    logic [71:0] n_out_data;
    logic        take;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_major   <= 32'd0;
            r_min_line    <= 32'd0;
            r_min_channel <= 4'd0;
            r_major_limit <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_MAJOR:   r_min_major   <= i_cfg_data;
                CFG_MIN_LINE:    r_min_line    <= i_cfg_data;
                CFG_MIN_CHANNEL: r_min_channel <= i_cfg_data[3:0];
                CFG_MAJOR_LIMIT: r_major_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lexicographic compare against the minimum
    assign ord_major = cmp_u32(i_res.major, r_min_major);
    assign ord_line  = cmp_u32(i_res.line, r_min_line);
    assign ord_chan  = cmp_channel(i_res.channel, r_min_channel);

    always_comb begin
        if (ord_major != ORD_EQUAL) begin
            ord = ord_major;
        end else if (ord_line != ORD_EQUAL) begin
            ord = ord_line;
        end else begin
            ord = ord_chan;
        end
        in_range = (ord != ORD_LOWER) && (i_res.major < r_major_limit);
    end

    // Result packing, all zero when malformed
    always_comb begin
        if (i_res.ok) begin
            n_out_data = {i_res.channel, i_res.line, i_res.major, ord, in_range, 1'b1};
        end else begin
            n_out_data = 72'd0;
        end
    end

    // Result register
    assign o_res_ready = !r_out_valid || i_ready;
    assign take        = i_res_valid && o_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

/* hw/rtl/version_string_range_check.sv */
// Version string range checker: one character per cycle; after the end-mark
// transfer the result passes the input register, then the result register.
// Throughput: one transfer per cycle while the result side takes results;
// an end mark waits in the input register while the result register is full.
// Reset (i_rst_n low, synchronous) clears the parser, the handshakes and sets
// the minimum to 0.0.0 and the major limit to all ones.
module version_string_range_check
    import vsrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // end_mark
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [0] format_ok, [1] in_range, [3:2] order,
                                        // [35:4] major_value, [67:36] line_value,
                                        // [71:68] channel_value
);

    logic       res_valid;
    logic       res_ready;
    t_parse_res res;

    vsrc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_char      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    vsrc_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

    // Malformed text gives an all-zero result
    a_malformed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata == 72'd0))
        else $error("malformed result carries nonzero fields");

    // In range needs a well-formed text not below the minimum
    a_range_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1])
            |-> (m_axis_tdata[0] && (m_axis_tdata[3:2] != ORD_LOWER)))
        else $error("in_range set on malformed or lower version");

    // Order code is never the unused value
    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:2] != 2'd3))
        else $error("illegal order code");

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
